>>> sv/itoa_pkg.sv
package itoa_pkg;

  // Width of the signed input word
  localparam int unsigned VALUE_BITS = 32;

  // Decimal digits needed for the largest magnitude, 2**VALUE_BITS - 1 bound
  localparam int unsigned DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int unsigned BCD_W = DIGITS * 4;
  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Double-dabble shift steps done in one pipeline stage
  localparam int unsigned STAGE_STEPS = 8;
  localparam int unsigned DABBLE_STAGES = (VALUE_BITS + STAGE_STEPS - 1) / STAGE_STEPS;

  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);

  typedef struct packed {
    logic                  neg;
    logic [BCD_W-1:0]      bcd;
    logic [VALUE_BITS-1:0] bin;
  } work_t;

endpackage

>>> sv/itoa_value_if.sv
interface itoa_value_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [itoa_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> sv/itoa_char_if.sv
interface itoa_char_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

>>> sv/itoa_dabble_stage.sv
module itoa_dabble_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  itoa_pkg::work_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output itoa_pkg::work_t data_o
);

  logic            valid_q, valid_d;
  itoa_pkg::work_t data_q, data_d;

  // Per step, for STAGE_STEPS steps: adjust every BCD nibble, then shift one magnitude bit into the BCD word
  always_comb begin
    itoa_pkg::work_t w;
    w = data_i;
    for (int s = 0; s < itoa_pkg::STAGE_STEPS; s++) begin
      for (int k = 0; k < itoa_pkg::DIGITS; k++) begin
        if (w.bcd[4*k +: 4] >= 4'd5) begin
          w.bcd[4*k +: 4] = w.bcd[4*k +: 4] + 4'd3;
        end
      end
      w.bcd = {w.bcd[itoa_pkg::BCD_W-2:0], w.bin[itoa_pkg::VALUE_BITS-1]};
      w.bin = {w.bin[itoa_pkg::VALUE_BITS-2:0], 1'b0};
    end
    data_d = w;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/itoa_serializer.sv
module itoa_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  itoa_pkg::work_t   data_i,
  itoa_char_if.source       out_o
);

  logic                        busy_q, busy_d;
  logic                        sign_q, sign_d;
  logic [itoa_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [3:0]                  digits_q [itoa_pkg::DIGITS];
  logic                        out_valid_q, out_valid_d;
  logic [itoa_pkg::CHAR_W-1:0] code_q, code_d;
  logic                        last_q, last_d;
  logic [itoa_pkg::IDX_W-1:0]  top_idx;
  logic [3:0]                  cur_digit;
  logic                        fire, done, load;

  // Highest nonzero digit; zero still yields one digit
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < itoa_pkg::DIGITS; k++) begin
      if (data_i.bcd[4*k +: 4] != 4'd0) begin
        top_idx = itoa_pkg::IDX_W'(k);
      end
    end
  end

  assign cur_digit = digits_q[idx_q];
  assign fire      = busy_q && (!out_valid_q || out_o.ready);
  assign done      = fire && !sign_q && (idx_q == '0);
  assign ready_o   = !busy_q || done;
  assign load      = valid_i && ready_o;

  always_comb begin
    busy_d      = busy_q;
    sign_d      = sign_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    last_d      = last_q;
    if (fire) begin
      out_valid_d = 1'b1;
      code_d      = sign_q ? itoa_pkg::CHAR_MINUS
                           : itoa_pkg::CHAR_ZERO + {2'b00, cur_digit};
      last_d      = !sign_q && (idx_q == '0);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      sign_d = data_i.neg;
      idx_d  = top_idx;
    end else if (fire) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - itoa_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      sign_q      <= sign_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    last_q <= last_d;
    if (load) begin
      for (int k = 0; k < itoa_pkg::DIGITS; k++) begin
        digits_q[k] <= data_i.bcd[4*k +: 4];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = code_q;
  assign out_o.last_char = last_q;

endmodule

>>> sv/signed_int_to_decimal_ascii.sv
// An accepted word passes stage 0, the dabble stages and the serializer registers
// before its first character is output. The single character output port gives one
// character per cycle unless out_o.ready is low; a number has 1 to 11 characters.
// Sign/magnitude and four dabble stages each take a word per cycle unless stalled.
// Reset (rst_ni low, asynchronous) empties every stage and the output register.
module signed_int_to_decimal_ascii (
  input  logic         clk_i,
  input  logic         rst_ni,
  itoa_value_if.sink   in_i,
  itoa_char_if.source  out_o
);

  localparam int unsigned NS = itoa_pkg::DABBLE_STAGES;

  // Stage 0 holds sign and magnitude; stages 1..NS hold BCD conversions, complete at NS
  itoa_pkg::work_t stage_data [NS+1];
  logic [NS:0]     stage_valid;
  logic [NS:0]     stage_ready;

  logic            s0_valid_q, s0_valid_d;
  itoa_pkg::work_t s0_data_q, s0_data_d;
  logic            in_ready;

  // Form the magnitude as unsigned so the most negative value stays exact
  always_comb begin
    s0_data_d.neg = in_i.value[itoa_pkg::VALUE_BITS-1];
    s0_data_d.bcd = '0;
    s0_data_d.bin = s0_data_d.neg ? (~in_i.value + itoa_pkg::VALUE_BITS'(1)) : in_i.value;
  end

  assign in_ready   = !s0_valid_q || stage_ready[0];
  assign in_i.ready = in_ready;
  assign s0_valid_d = in_ready ? in_i.valid : s0_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s0_data_q <= s0_data_d;
    end
  end

  assign stage_valid[0] = s0_valid_q;
  assign stage_data[0]  = s0_data_q;

  // Each stage shifts STAGE_STEPS magnitude bits into the BCD digits
  for (genvar g = 0; g < NS; g++) begin : g_dabble
    itoa_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  // Walk the digits, minus sign first, one character word per cycle unless out_o.ready is low
  itoa_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NS]),
    .ready_o (stage_ready[NS]),
    .data_i  (stage_data[NS]),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // A stalled sign/magnitude word must hold until the first dabble stage takes it
  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !stage_ready[0] |=> s0_valid_q && $stable(s0_data_q))
    else $error("stage 0 word lost or changed under stall");

  // The minus sign always precedes at least one digit
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.char_code == itoa_pkg::CHAR_MINUS) |-> !out_o.last_char)
    else $error("minus sign flagged as last character");

  // Only the minus sign or a decimal digit leaves the block
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code == itoa_pkg::CHAR_MINUS) ||
                    ((out_o.char_code >= itoa_pkg::CHAR_ZERO) &&
                     (out_o.char_code <= itoa_pkg::CHAR_NINE)))
    else $error("character code out of range");
`endif

endmodule
